// ===== src/bct_pkg.sv =====
// Shared constants and types for the binomial coefficient table.
package bct_pkg;

  // Width of one table entry and of the result coefficient.
  localparam int DW = 30;

  // Width of each input argument field.
  localparam int FW = 6;

  // Position of the entry being built, as seen by the entry unit.
  typedef struct packed {
    logic row_zero;
    logic col_zero;
  } entry_ctl_t;

endpackage

// ===== src/binomial_coefficient_table.sv =====
// Top level of the binomial coefficient table: sequencer, table and result register.
//
//  Channel | Ports                     | Payload
//  --------+---------------------------+---------------------------------------
//  input   | in_tvalid/tready/tdata    | tdata: n_value, k_value
//  result  | out_tvalid/tready/tdata/  | tdata: coefficient; tuser: range_error
//          | out_tuser                 |
//
// A query with a range error or a folded k of zero goes from its transfer via the
// done state to the result register. A lookup inside the filled part of the table
// passes through plan, memory read, read data and result. Growing the table reads
// and writes each new entry and plans each growth phase once, all through the one
// entry adder and the table's single write port. Reset is synchronous and needs no
// clearing pass: every read entry has been written first. A waiting result holds
// only the final handoff; the next query is accepted while it waits.
module binomial_coefficient_table
  import bct_pkg::*;
#(
  parameter int MAX_N = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [5:0] n_value, [11:6] k_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [29:0] coefficient
  output logic [0:0]  out_tuser   // [0] range_error
);

  localparam int ROWS = MAX_N / 2 + 1;
  localparam int COLS = MAX_N;
  localparam int NW   = $clog2(MAX_N + 1);
  localparam int VW   = (NW > FW) ? NW : FW;
  localparam int RW   = $clog2(ROWS);
  localparam int JW   = $clog2(COLS);
  localparam int AW   = RW + JW;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PLAN  = 7'b0000010,
    S_RD    = 7'b0000100,
    S_WR    = 7'b0001000,
    S_LOOK  = 7'b0010000,
    S_LOOKW = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [VW-1:0] n_r, n_nxt;
  logic [VW-1:0] k_r, k_nxt;
  logic [VW-1:0] fn_r, fn_nxt;
  logic [VW-1:0] fk_r, fk_nxt;
  logic [VW-1:0] r_r, r_nxt;
  logic [VW-1:0] j_r, j_nxt;
  logic [VW-1:0] rend_r, rend_nxt;
  logic [VW-1:0] jstart_r, jstart_nxt;
  logic [VW-1:0] jend_r, jend_nxt;
  logic          phase_b_r, phase_b_nxt;
  logic [DW-1:0] res_r, res_nxt;
  logic          err_r, err_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [DW-1:0] out_coef_r;
  logic          out_err_r;

  // Input fields and the range check and fold done at the transfer.
  logic [FW-1:0] n_in, k_in, diff_in, kf_in;
  logic          err_in;

  assign n_in    = in_tdata[FW-1:0];
  assign k_in    = in_tdata[2*FW-1:FW];
  assign err_in  = (VW'(n_in) > VW'(MAX_N)) || (k_in > n_in);
  assign diff_in = n_in - k_in;
  assign kf_in   = (diff_in < k_in) ? diff_in : k_in;

  // Table addresses: left and above neighbors while building, result on lookup.
  logic [VW-1:0] jm1, rm1, km1, lcol;
  logic [AW-1:0] raddr_a, raddr_b, waddr;
  logic [DW-1:0] rdata_a, rdata_b, entry_val;
  logic          we;
  entry_ctl_t    ectl;
  logic [VW-1:0] eidx;

  assign jm1     = j_r - VW'(1);
  assign rm1     = r_r - VW'(1);
  assign km1     = k_r - VW'(1);
  assign lcol    = n_r - k_r - VW'(1);
  assign raddr_a = (state_r == S_LOOK) ? {km1[RW-1:0], lcol[JW-1:0]}
                                       : {r_r[RW-1:0], jm1[JW-1:0]};
  assign raddr_b = {rm1[RW-1:0], j_r[JW-1:0]};
  assign waddr   = {r_r[RW-1:0], j_r[JW-1:0]};
  assign we      = (state_r == S_WR);

  assign ectl.row_zero = (r_r == '0);
  assign ectl.col_zero = (j_r == '0);
  assign eidx          = ectl.row_zero ? j_r : r_r;

  bct_mem #(
    .AW (AW)
  ) u_mem (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (entry_val),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  bct_entry #(
    .IW (VW)
  ) u_entry (
    .ctl   (ectl),
    .idx   (eidx),
    .left  (rdata_a),
    .above (rdata_b),
    .value (entry_val)
  );

  assign in_tready = (state_r == S_IDLE);

  // Sequencer: plan growth, walk the table one entry at a time, then look up.
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    fn_nxt        = fn_r;
    fk_nxt        = fk_r;
    r_nxt         = r_r;
    j_nxt         = j_r;
    rend_nxt      = rend_r;
    jstart_nxt    = jstart_r;
    jend_nxt      = jend_r;
    phase_b_nxt   = phase_b_r;
    res_nxt       = res_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          n_nxt = VW'(n_in);
          k_nxt = VW'(kf_in);
          if (err_in) begin
            res_nxt   = '0;
            err_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else if (kf_in == '0) begin
            res_nxt   = DW'(1);
            err_nxt   = 1'b0;
            state_nxt = S_DONE;
          end else begin
            err_nxt   = 1'b0;
            state_nxt = S_PLAN;
          end
        end
      end
      S_PLAN: begin
        // Lengthen existing rows first, then add new rows.
        if (n_r > fn_r) begin
          phase_b_nxt = 1'b0;
          r_nxt       = '0;
          j_nxt       = fn_r - VW'(1);
          jstart_nxt  = fn_r - VW'(1);
          jend_nxt    = n_r - VW'(2);
          rend_nxt    = fk_r;
          state_nxt   = S_RD;
        end else if (k_r > fk_r) begin
          phase_b_nxt = 1'b1;
          r_nxt       = fk_r;
          j_nxt       = '0;
          jstart_nxt  = '0;
          jend_nxt    = fn_r - VW'(2);
          rend_nxt    = k_r;
          state_nxt   = S_RD;
        end else begin
          state_nxt = S_LOOK;
        end
      end
      S_RD: begin
        state_nxt = S_WR;
      end
      S_WR: begin
        // Step to the next entry, row by row.
        if (j_r == jend_r) begin
          if (r_r + VW'(1) == rend_r) begin
            if (phase_b_r) begin
              fk_nxt = k_r;
            end else begin
              fn_nxt = n_r;
            end
            state_nxt = S_PLAN;
          end else begin
            r_nxt     = r_r + VW'(1);
            j_nxt     = jstart_r;
            state_nxt = S_RD;
          end
        end else begin
          j_nxt     = j_r + VW'(1);
          state_nxt = S_RD;
        end
      end
      S_LOOK: begin
        state_nxt = S_LOOKW;
      end
      S_LOOKW: begin
        res_nxt   = rdata_a;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fn_r        <= VW'(1);
      fk_r        <= VW'(1);
      out_valid_r <= 1'b0;
      phase_b_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fn_r        <= fn_nxt;
      fk_r        <= fk_nxt;
      out_valid_r <= out_valid_nxt;
      phase_b_r   <= phase_b_nxt;
    end
  end

  // Working registers and the result register.
  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    k_r      <= k_nxt;
    r_r      <= r_nxt;
    j_r      <= j_nxt;
    rend_r   <= rend_nxt;
    jstart_r <= jstart_nxt;
    jend_r   <= jend_nxt;
    res_r    <= res_nxt;
    err_r    <= err_nxt;
    if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_coef_r <= res_r;
      out_err_r  <= err_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {{(32 - DW){1'b0}}, out_coef_r};
  assign out_tuser[0] = out_err_r;

  // The walk never writes outside the column span planned for this phase.
  a_walk_cols: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) |-> (j_r >= jstart_r && j_r <= jend_r))
    else $error("table walk column outside planned span");

  // The filled column extent only grows and stays within the table.
  a_fn_grow: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (fn_r >= $past(fn_r) && fn_r <= VW'(MAX_N)))
    else $error("filled column extent shrank or overflowed");

  // A lookup only reads an entry that lies inside the filled part.
  a_look_filled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOK) |-> (k_r <= fk_r && n_r - k_r + VW'(1) <= fn_r))
    else $error("lookup outside filled table");

  // A result flagged as a range error carries a zero coefficient.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_coef_r == '0))
    else $error("range error result with nonzero coefficient");

endmodule

// ===== src/bct_mem.sv =====
// Pascal table storage: one write port and two registered read ports.
module bct_mem
  import bct_pkg::*;
#(
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);

  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Both read ports are registered: data appears in the cycle after the address.
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== src/bct_entry.sv =====
// Entry unit: the single adder that builds one table entry from its neighbors.
module bct_entry
  import bct_pkg::*;
#(
  parameter int IW = 6
) (
  input  entry_ctl_t    ctl,
  input  logic [IW-1:0] idx,
  input  logic [DW-1:0] left,
  input  logic [DW-1:0] above,
  output logic [DW-1:0] value
);

  // Edge entries are the index plus two; inner entries add left and above.
  // The sum wraps at the entry width.
  always_comb begin
    if (ctl.row_zero || ctl.col_zero) begin
      value = DW'(idx) + DW'(2);
    end else begin
      value = left + above;
    end
  end

endmodule
